FILE: hdl/kcfa_pkg.sv
// ----------------------------------------------------------------------------
// kcfa_pkg
// Shared types and constants of the keyframe color fade animator.
// ----------------------------------------------------------------------------
package kcfa_pkg;

  typedef enum logic [1:0] {
    FN_TICK,
    FN_WR_ONE,
    FN_WR_ALL,
    FN_START
  } func_t;

  typedef struct packed {
    func_t       func;
    logic [15:0] elapsed;
    logic [3:0]  key_index;
    logic [31:0] key_color;
  } in_item_t;

  typedef struct packed {
    logic [31:0] blend_color;
    logic [3:0]  frame_index;
    logic [7:0]  tile_index;
    logic        visible;
    logic [7:0]  weight;
  } out_item_t;

  localparam int          CFG_IDX_W  = 3;
  localparam int          CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 3'd4;

  localparam logic [31:0] KEY_RESET_COLOR = 32'hffff_ffff;

  localparam logic [2:0]  DIV_LAST   = 3'd7;
  localparam logic [2:0]  BLEND_LAST = 3'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALL,
    ST_DIV_INIT,
    ST_DIV,
    ST_READ,
    ST_BLEND,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic wall_step;
    logic div_init;
    logic div_step;
    logic rd_keys;
    logic blend_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    func_t func;
    logic  sweep_last;
    logic  do_blend;
    logic  out_free;
  } dp_stat_t;

endpackage

FILE: hdl/kcfa_ctrl.sv
// ----------------------------------------------------------------------------
// kcfa_ctrl
// Sequencer: request decode, write-all sweep, weight division steps, channel
// blend steps and result hand-off.
// ----------------------------------------------------------------------------
module kcfa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  kcfa_pkg::dp_stat_t stat,
  output kcfa_pkg::dp_cmd_t  cmd
);
  import kcfa_pkg::*;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.func == FN_WR_ALL) state_nxt = ST_WALL;
        else                        state_nxt = ST_DIV_INIT;
      end
      ST_WALL: begin
        cmd.wall_step = 1'b1;
        if (stat.sweep_last) state_nxt = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 3'd1;
        if (cnt_r == DIV_LAST) state_nxt = stat.do_blend ? ST_READ : ST_DONE;
      end
      ST_READ: begin
        cmd.rd_keys = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = ST_BLEND;
      end
      ST_BLEND: begin
        cmd.blend_step = 1'b1;
        cnt_nxt        = cnt_r + 3'd1;
        if (cnt_r == BLEND_LAST) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: hdl/kcfa_dp.sv
// ----------------------------------------------------------------------------
// kcfa_dp
// Datapath: config registers, keyframe memory, frame and tile timers,
// restoring weight divider, channel-serial blender and output register.
// ----------------------------------------------------------------------------
module kcfa_dp #(
  parameter int MAX_KEYS  = 16,
  parameter int TIME_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  kcfa_pkg::in_item_t                  in_data,
  input  logic                                cfg_valid,
  input  logic [kcfa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kcfa_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                out_ready,
  output logic                                out_valid,
  output kcfa_pkg::out_item_t                 out_data,
  input  kcfa_pkg::dp_cmd_t                   cmd,
  output kcfa_pkg::dp_stat_t                  stat
);
  import kcfa_pkg::*;

  localparam int KW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int FW = $clog2(MAX_KEYS + 1);
  localparam int TB = TIME_BITS;
  localparam int TW = TIME_BITS + 1;

  // config
  logic [4:0]  frame_count_r;
  logic [15:0] frame_ticks_r;
  logic [15:0] tile_ticks_r;
  logic [8:0]  tile_count_r;
  logic        loop_r;

  // state
  in_item_t    item_r;
  logic [TW-1:0] frame_timer_r, tile_timer_r;
  logic [KW-1:0] cur_frame_r, sweep_r;
  logic [7:0]    cur_tile_r;
  logic          shown_r, do_blend_r;
  logic [31:0]   last_color_r;

  // keyframe store
  logic [31:0]         key_mem [MAX_KEYS];
  logic [MAX_KEYS-1:0] kvalid_r;
  logic [31:0]         cur_raw_r, nxt_raw_r;
  logic                cur_ok_r, nxt_ok_r;

  // divider
  logic [TB-1:0] rem_r;
  logic [7:0]    quo_r;
  logic          sat_r;

  logic          out_valid_r;
  out_item_t     out_r;

  // combinational
  logic [FW-1:0] n_frames;
  logic          last_frame;
  logic [KW-1:0] next_frame;
  logic [TB-1:0] fdiv, tdiv, dt;
  logic [TW-1:0] fsum, tsum, r2;
  logic          frame_due, stop;
  logic [8:0]    n_tiles, tile_inc;
  logic          tile_wrap;
  logic          tick_en, start_en, wr_one_en, mem_we;
  logic [KW-1:0] mem_wa;
  logic [7:0]    weight;
  logic [7:0]    ca, cb;
  logic signed [8:0]  diff;
  logic signed [8:0]  wsg;
  logic signed [17:0] prod, bsum;
  logic [7:0]    chan;

  always_comb begin
    if (frame_count_r == 5'd0)                     n_frames = FW'(1);
    else if (32'(frame_count_r) > 32'(MAX_KEYS))   n_frames = FW'(MAX_KEYS);
    else                                           n_frames = FW'(frame_count_r);
    if (tile_count_r == 9'd0)        n_tiles = 9'd1;
    else if (tile_count_r > 9'd256)  n_tiles = 9'd256;
    else                             n_tiles = tile_count_r;
    fdiv = TB'(frame_ticks_r);
    if (fdiv == '0) fdiv = TB'(1);
    tdiv = TB'(tile_ticks_r);
    if (tdiv == '0) tdiv = TB'(1);
  end

  assign last_frame = (32'(cur_frame_r) + 32'd1) >= 32'(n_frames);
  assign next_frame = last_frame ? cur_frame_r : cur_frame_r + KW'(1);
  assign dt         = TB'(item_r.elapsed);
  assign fsum       = frame_timer_r + TW'(dt);
  assign tsum       = tile_timer_r + TW'(dt);
  assign frame_due  = fsum >= TW'(fdiv);
  assign stop       = frame_due && last_frame && !loop_r;
  assign tile_inc   = {1'b0, cur_tile_r} + 9'd1;
  assign tile_wrap  = tile_inc >= n_tiles;

  assign tick_en   = cmd.exec && (item_r.func == FN_TICK) && shown_r;
  assign start_en  = cmd.exec && (item_r.func == FN_START);
  assign wr_one_en = cmd.exec && (item_r.func == FN_WR_ONE)
                     && (32'(item_r.key_index) < 32'(MAX_KEYS));
  assign mem_we    = wr_one_en || cmd.wall_step;
  assign mem_wa    = cmd.wall_step ? sweep_r : KW'(item_r.key_index);

  assign weight = sat_r ? 8'hff : quo_r;
  assign r2     = {rem_r, 1'b0};

  assign ca   = cur_ok_r ? cur_raw_r[7:0] : 8'hff;
  assign cb   = nxt_ok_r ? nxt_raw_r[7:0] : 8'hff;
  assign diff = $signed({1'b0, cb}) - $signed({1'b0, ca});
  assign wsg  = $signed({1'b0, weight});
  assign prod = diff * wsg;
  assign bsum = $signed({2'b00, ca, 8'h80}) + prod;
  assign chan = bsum[15:8];

  // config and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= 5'd1;
      frame_ticks_r <= 16'd100;
      tile_ticks_r  <= 16'd100;
      tile_count_r  <= 9'd1;
      loop_r        <= 1'b0;
      frame_timer_r <= '0;
      tile_timer_r  <= '0;
      cur_frame_r   <= '0;
      cur_tile_r    <= '0;
      shown_r       <= 1'b0;
      do_blend_r    <= 1'b0;
      last_color_r  <= '0;
      sweep_r       <= '0;
      kvalid_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_FRAME_COUNT: frame_count_r <= cfg_data[4:0];
          CFG_FRAME_TICKS: frame_ticks_r <= cfg_data;
          CFG_TILE_TICKS:  tile_ticks_r  <= cfg_data;
          CFG_TILE_COUNT:  tile_count_r  <= cfg_data[8:0];
          CFG_LOOP_ENABLE: loop_r        <= cfg_data[0];
          default: ;
        endcase
      end

      if (cmd.load_in) begin
        do_blend_r <= 1'b0;
        sweep_r    <= '0;
      end
      if (cmd.wall_step) sweep_r <= sweep_r + KW'(1);
      if (mem_we) kvalid_r[mem_wa] <= 1'b1;

      if (start_en) begin
        cur_frame_r   <= '0;
        frame_timer_r <= '0;
        cur_tile_r    <= '0;
        tile_timer_r  <= '0;
        shown_r       <= 1'b1;
      end else if (tick_en) begin
        do_blend_r <= !stop;
        if (stop) begin
          shown_r       <= 1'b0;
          frame_timer_r <= fsum;
        end else begin
          if (frame_due) begin
            frame_timer_r <= '0;
            cur_frame_r   <= last_frame ? '0 : cur_frame_r + KW'(1);
          end else begin
            frame_timer_r <= fsum;
          end
          if (tsum >= TW'(tdiv)) begin
            tile_timer_r <= '0;
            cur_tile_r   <= tile_wrap ? 8'd0 : tile_inc[7:0];
          end else begin
            tile_timer_r <= tsum;
          end
        end
      end

      if (cmd.blend_step) last_color_r <= {chan, last_color_r[31:8]};

      if (cmd.load_out)  out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // keyframe memory
  always_ff @(posedge clk) begin
    if (mem_we) key_mem[mem_wa] <= item_r.key_color;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_keys) begin
      cur_raw_r <= key_mem[cur_frame_r];
      nxt_raw_r <= key_mem[next_frame];
      cur_ok_r  <= kvalid_r[cur_frame_r];
      nxt_ok_r  <= kvalid_r[next_frame];
    end else if (cmd.blend_step) begin
      cur_raw_r <= cur_raw_r >> 8;
      nxt_raw_r <= nxt_raw_r >> 8;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) item_r <= in_data;
    if (cmd.div_init) begin
      sat_r <= frame_timer_r >= TW'(fdiv);
      rem_r <= TB'(frame_timer_r);
      quo_r <= '0;
    end else if (cmd.div_step) begin
      if (r2 >= TW'(fdiv)) begin
        rem_r <= TB'(r2 - TW'(fdiv));
        quo_r <= {quo_r[6:0], 1'b1};
      end else begin
        rem_r <= TB'(r2);
        quo_r <= {quo_r[6:0], 1'b0};
      end
    end
    if (cmd.load_out) begin
      out_r.blend_color <= last_color_r;
      out_r.frame_index <= 4'(cur_frame_r);
      out_r.tile_index  <= cur_tile_r;
      out_r.visible     <= shown_r;
      out_r.weight      <= weight;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_r;
  assign stat.func       = item_r.func;
  assign stat.sweep_last = (32'(sweep_r) + 32'd1) == 32'(n_frames);
  assign stat.do_blend   = do_blend_r;
  assign stat.out_free   = !out_valid_r || out_ready;

endmodule

FILE: hdl/keyframe_color_fade_animator_core.sv
// ----------------------------------------------------------------------------
// keyframe_color_fade_animator_core
// Keyframe ARGB color fade with frame and sprite-tile timers.
// ----------------------------------------------------------------------------
// One request is handled at a time and each gives one result. A tick that
// updates the color passes through a decode step, an 8-step restoring
// divider for the blend weight, one keyframe memory read and a 4-step blend
// that runs one ARGB channel per cycle through a single multiplier. Other
// requests skip the read and blend; a write-all request also sweeps each
// keyframe slot in use in turn, since the keyframe memory has one write
// port. A finished result waits in the output register while the next
// request is accepted. Configuration writes are taken at any time
// (cfg_ready is always high).
// ----------------------------------------------------------------------------
module keyframe_color_fade_animator_core #(
  parameter int MAX_KEYS  = 16,
  parameter int TIME_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  kcfa_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output kcfa_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kcfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kcfa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import kcfa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  kcfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kcfa_dp #(
    .MAX_KEYS  (MAX_KEYS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
